@@ rtl/ddramp_pkg.sv @@
// ddramp_pkg: shared constants, request and register codes and the
// controller to datapath command/status types of the differential drive ramp
// no dependencies
`timescale 1ns / 1ps

package ddramp_pkg;

	localparam int SPEED_WIDTH     = 12;
	localparam int FRAC_BITS       = 15;
	localparam int RAMP_STEP_RESET = 200;

	// request kinds carried in tuser
	localparam logic [1:0] REQ_DRIVE = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_RAMP_STEP = 2'd0;
	localparam logic [1:0] REG_MIN_LEFT  = 2'd1;
	localparam logic [1:0] REG_MIN_RIGHT = 2'd2;

	// motor sense codes
	localparam logic [1:0] SENSE_STOP = 2'd0;
	localparam logic [1:0] SENSE_CW   = 2'd1;
	localparam logic [1:0] SENSE_CCW  = 2'd2;

	typedef struct packed {
		logic       accept;    // request taken this cycle
		logic [1:0] kind;      // request kind, valid with accept
		logic       mul1;      // |n| * m
		logic       mul2;      // * max_speed, divider load
		logic       div_step;  // one quotient bit
		logic       store;     // write target of current lane
		logic       lane;      // 0 left, 1 right
		logic       emit;      // load output register
	} ddramp_cmd_t;

	typedef struct packed {
		logic out_free;        // output register can take a result
	} ddramp_stat_t;

endpackage

@@ rtl/ddramp_ctrl.sv @@
// ddramp_ctrl: sequencer of the differential drive ramp
// depends on ddramp_pkg (command and status types, request codes)
`timescale 1ns / 1ps

module ddramp_ctrl #(
	parameter int SW = ddramp_pkg::SPEED_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [1:0]                req_type,
	input  ddramp_pkg::ddramp_stat_t  stat,
	output ddramp_pkg::ddramp_cmd_t   cmd
);

	localparam int CNTW = $clog2(SW);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL1  = 3'd1;
	localparam logic [2:0] ST_MUL2  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_STORE = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]      state_q, state_d;
	logic            lane_q, lane_d;
	logic [CNTW-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d  = state_q;
		lane_d   = lane_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.lane = lane_q;
		cmd.kind = req_type;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (req_type == ddramp_pkg::REQ_DRIVE) begin
						lane_d  = 1'b0;
						state_d = ST_MUL1;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNTW'(SW - 1)) state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				if (lane_q) begin
					state_d = ST_EMIT;
				end else begin
					lane_d  = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lane_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			lane_q  <= lane_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

@@ rtl/ddramp_dp.sv @@
// ddramp_dp: datapath of the differential drive ramp: config registers,
// mixer with shared multiplier chain and restoring divider, ramp and output
// depends on ddramp_pkg (command and status types, codes, reset values)
`timescale 1ns / 1ps

module ddramp_dp #(
	parameter int SW = ddramp_pkg::SPEED_WIDTH,
	parameter int F  = ddramp_pkg::FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ddramp_pkg::ddramp_cmd_t   cmd,
	output ddramp_pkg::ddramp_stat_t  stat,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [SW-1:0]             cfg_data,
	input  logic signed [15:0]        throttle,
	input  logic signed [15:0]        direction,
	input  logic [SW-1:0]             max_speed,
	input  logic                      m_tready,
	output logic                      m_tvalid,
	output logic [1:0]                left_sense,
	output logic [SW-1:0]             left_duty,
	output logic [1:0]                right_sense,
	output logic [SW-1:0]             right_duty,
	output logic                      drive_updated
);

	localparam int CW  = F + 2;         // clamped demand, signed
	localparam int MW  = F + 1;         // demand magnitude
	localparam int NW  = F + 3;         // mix combination, signed
	localparam int NMW = F + 2;         // its magnitude
	localparam int DW  = F + 2;         // denominator factor
	localparam int TW  = MW + 4;        // deadband compare
	localparam int P1W = NMW + MW;
	localparam int P2W = P1W + SW;

	localparam logic signed [16:0]   ONE_X = 17'(1 << F);
	localparam logic signed [CW-1:0] ONE_C = CW'(1 << F);

	function automatic logic signed [CW-1:0] clamp_one(input logic signed [15:0] x);
		logic signed [16:0] xe;
		xe = {x[15], x};
		if (xe > ONE_X) clamp_one = ONE_C;
		else if (xe < -ONE_X) clamp_one = -ONE_C;
		else clamp_one = xe[CW-1:0];
	endfunction

	function automatic logic signed [SW:0] ramp_to(input logic signed [SW:0] cur,
		input logic signed [SW:0] tgt, input logic [SW-1:0] step);
		logic signed [SW+1:0] c, t, up, dn;
		c  = {cur[SW], cur};
		t  = {tgt[SW], tgt};
		up = c + $signed({2'b00, step});
		dn = c - $signed({2'b00, step});
		if (t > up) ramp_to = up[SW:0];
		else if (t < dn) ramp_to = dn[SW:0];
		else ramp_to = tgt;
	endfunction

	// configuration
	logic [SW-1:0] ramp_step_q, min_left_q, min_right_q;

	// motor state
	logic signed [SW:0] cur_l_q, cur_r_q, tgt_l_q, tgt_r_q;
	logic               upd_q;

	// command operands and arithmetic
	logic signed [CW-1:0] t_q, d_q;
	logic [SW-1:0]        maxs_q;
	logic [P1W-1:0]       p1_q;
	logic                 neg_q;
	logic [P2W-1:0]       rem_q, dv_q;
	logic [SW-1:0]        quo_q;

	logic [MW-1:0]        mag_t, mag_d, m;
	logic [TW-1:0]        t_ext, t10;
	logic                 deadband;
	logic [DW-1:0]        den;
	logic signed [NW-1:0] te, de, nl, nr, n_sel;
	logic [NMW-1:0]       n_mag;
	logic                 ge;
	logic [SW-1:0]        lo, adj;
	logic signed [SW:0]   tgt_v, nxt_l, nxt_r;

	always_comb begin
		mag_t    = t_q[CW-1] ? MW'(-t_q) : MW'(t_q);
		mag_d    = d_q[CW-1] ? MW'(-d_q) : MW'(d_q);
		m        = (mag_t > mag_d) ? mag_t : mag_d;
		t_ext    = TW'(mag_t);
		t10      = (t_ext << 3) + (t_ext << 1);
		deadband = t10 < TW'(1 << F);
		te       = {t_q[CW-1], t_q};
		de       = {d_q[CW-1], d_q};
		// on the spot turn divides by one squared, otherwise by one * (|t|+|d|)
		if (deadband) begin
			den = DW'(1 << F);
			nl  = de;
			nr  = -de;
		end else begin
			den = DW'(mag_t) + DW'(mag_d);
			if (t_q > 0 && d_q >= 0) begin
				nl = te + de;
				nr = te;
			end else if (t_q < 0 && d_q < 0) begin
				nl = te;
				nr = te + de;
			end else if (t_q < 0 && d_q > 0) begin
				nl = te - de;
				nr = te;
			end else begin
				nl = te;
				nr = te - de;
			end
		end
		n_sel = cmd.lane ? nr : nl;
		n_mag = n_sel[NW-1] ? NMW'(-n_sel) : NMW'(n_sel);
		ge    = rem_q >= dv_q;
		lo    = cmd.lane ? min_right_q : min_left_q;
		adj   = (quo_q != '0 && quo_q < lo) ? lo : quo_q;
		tgt_v = neg_q ? -$signed({1'b0, adj}) : $signed({1'b0, adj});
		nxt_l = ramp_to(cur_l_q, tgt_l_q, ramp_step_q);
		nxt_r = ramp_to(cur_r_q, tgt_r_q, ramp_step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q <= SW'(ddramp_pkg::RAMP_STEP_RESET);
			min_left_q  <= '0;
			min_right_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ddramp_pkg::REG_RAMP_STEP: ramp_step_q <= cfg_data;
				ddramp_pkg::REG_MIN_LEFT:  min_left_q  <= cfg_data;
				ddramp_pkg::REG_MIN_RIGHT: min_right_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_l_q <= '0;
			cur_r_q <= '0;
			tgt_l_q <= '0;
			tgt_r_q <= '0;
			upd_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				case (cmd.kind)
					ddramp_pkg::REQ_DRIVE: upd_q <= 1'b0;
					ddramp_pkg::REQ_TICK: begin
						cur_l_q <= nxt_l;
						cur_r_q <= nxt_r;
						upd_q   <= (nxt_l != cur_l_q) || (nxt_r != cur_r_q);
					end
					ddramp_pkg::REQ_STOP: begin
						cur_l_q <= '0;
						cur_r_q <= '0;
						tgt_l_q <= '0;
						tgt_r_q <= '0;
						upd_q   <= 1'b1;
					end
					default: upd_q <= 1'b0;
				endcase
			end
			if (cmd.store) begin
				if (cmd.lane) tgt_r_q <= tgt_v;
				else tgt_l_q <= tgt_v;
			end
		end
	end

	// operand capture, multiplier chain and divider
	always_ff @(posedge clk) begin
		if (cmd.accept && cmd.kind == ddramp_pkg::REQ_DRIVE) begin
			t_q    <= clamp_one(throttle);
			d_q    <= clamp_one(direction);
			maxs_q <= max_speed;
		end
		if (cmd.mul1) begin
			p1_q  <= n_mag * m;
			neg_q <= n_sel[NW-1];
		end
		if (cmd.mul2) begin
			rem_q <= p1_q * maxs_q;
			dv_q  <= P2W'({den, {F{1'b0}}}) << (SW - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (ge) rem_q <= rem_q - dv_q;
			dv_q  <= dv_q >> 1;
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			left_sense    <= (cur_l_q > 0) ? ddramp_pkg::SENSE_CW :
				(cur_l_q < 0) ? ddramp_pkg::SENSE_CCW : ddramp_pkg::SENSE_STOP;
			left_duty     <= cur_l_q[SW] ? SW'(-cur_l_q) : SW'(cur_l_q);
			right_sense   <= (cur_r_q > 0) ? ddramp_pkg::SENSE_CW :
				(cur_r_q < 0) ? ddramp_pkg::SENSE_CCW : ddramp_pkg::SENSE_STOP;
			right_duty    <= cur_r_q[SW] ? SW'(-cur_r_q) : SW'(cur_r_q);
			drive_updated <= upd_q;
		end
	end

	assign stat.out_free = !m_tvalid || m_tready;

endmodule

@@ rtl/differential_drive_ramp.sv @@
// differential_drive_ramp: top level of the two-track drive mixer and ramp
// depends on ddramp_pkg, ddramp_ctrl and ddramp_dp
`timescale 1ns / 1ps

// Usage
// - s_* channel takes one request: tuser is the kind (drive command, tick,
//   stop), tdata holds throttle, direction (Q1.15) and max_speed
// - every request gives exactly one result on m_*: sense and duty of both
//   motors as they stand after the request, tuser flags a rewrite
// - a drive command only sets new targets; it runs the mixer through one
//   shared multiplier chain and a restoring divider, one quotient bit per
//   cycle, left then right lane, then hands the result to the output register
// - tick, stop and unused kinds finish in the accepting cycle; the result
//   passes the emit state into the output register once that register is free
// - one request at a time: the next is taken as soon as the result sits in
//   the output register
// - if the receiver stalls, the result holds in the output register and the
//   block can take and finish the next request, which then waits to emit
// - cfg_* writes a register at any cycle (ready always high); write only
//   while no request is in flight
// - reset: speeds and targets zero, ramp_step 200, minimum speeds zero,
//   no result pending, s_tready high in the first cycle after reset

module differential_drive_ramp #(
	parameter int SPEED_WIDTH = ddramp_pkg::SPEED_WIDTH,
	parameter int FRAC_BITS   = ddramp_pkg::FRAC_BITS,
	localparam int IN_W  = ((32 + SPEED_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((4 + 2 * SPEED_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request channel
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_W-1:0]        s_tdata,   // throttle, direction, max_speed, zero pad
	input  logic [1:0]             s_tuser,   // req_type
	// result channel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_W-1:0]       m_tdata,   // left_sense, left_duty, right_sense,
	                                          // right_duty, zero pad
	output logic                   m_tuser,   // drive_updated
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [SPEED_WIDTH-1:0] cfg_data
);

	ddramp_pkg::ddramp_cmd_t  cmd;
	ddramp_pkg::ddramp_stat_t stat;

	logic [1:0]             left_sense, right_sense;
	logic [SPEED_WIDTH-1:0] left_duty, right_duty;

	// register file always takes a write
	assign cfg_ready = 1'b1;

	ddramp_ctrl #(
		.SW(SPEED_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	ddramp_dp #(
		.SW(SPEED_WIDTH),
		.F (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.throttle      ($signed(s_tdata[15:0])),
		.direction     ($signed(s_tdata[31:16])),
		.max_speed     (s_tdata[32 +: SPEED_WIDTH]),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.left_sense    (left_sense),
		.left_duty     (left_duty),
		.right_sense   (right_sense),
		.right_duty    (right_duty),
		.drive_updated (m_tuser)
	);

	// pack result fields from the lowest bit up, zero padded
	assign m_tdata = OUT_W'({right_duty, right_sense, left_duty, left_sense});

endmodule

@@ rtl/ddramp_checker.sv @@
// ddramp_checker: port-level assertions for differential_drive_ramp and
// the bind that attaches them; depends on ddramp_pkg and the top level
`timescale 1ns / 1ps

module ddramp_checker #(
	parameter int SW = ddramp_pkg::SPEED_WIDTH,
	localparam int OUT_W = ((4 + 2 * SW + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	// one request in flight: no back-to-back accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while previous one still in work");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// stopped sense goes with zero duty and a running motor with nonzero duty
	a_left_sense: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[1:0] == ddramp_pkg::SENSE_STOP) ==
			(m_tdata[2 +: SW] == '0)) && (m_tdata[1:0] != 2'd3))
		else $error("left sense and duty disagree");

	a_right_sense: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[2 + SW +: 2] == ddramp_pkg::SENSE_STOP) ==
			(m_tdata[4 + SW +: SW] == '0)) && (m_tdata[2 + SW +: 2] != 2'd3))
		else $error("right sense and duty disagree");

endmodule

bind differential_drive_ramp ddramp_checker #(
	.SW(SPEED_WIDTH)
) u_ddramp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for the differential drive mixer and ramp; a
// tracker class mirrors targets and speeds and checks every result in order
// depends on ddramp_pkg and differential_drive_ramp
`timescale 1ns / 1ps

module tb_top;

	localparam int  SPEED_WIDTH = ddramp_pkg::SPEED_WIDTH;
	localparam int  FRAC_BITS   = ddramp_pkg::FRAC_BITS;
	localparam int  IN_W        = ((32 + SPEED_WIDTH + 7) / 8) * 8;
	localparam int  OUT_W       = ((4 + 2 * SPEED_WIDTH + 7) / 8) * 8;
	localparam longint UNITY    = longint'(1) << FRAC_BITS;
	localparam int  CYCLE_LIMIT = 1000000;
	localparam int  HOLD_CYCLES = 400;
	// long enough to cover a whole drive command including the handover
	localparam int  SETTLE_CYCLES = 40;

	// unused codes, exercised on purpose
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]             lsense;
		logic [SPEED_WIDTH-1:0] lduty;
		logic [1:0]             rsense;
		logic [SPEED_WIDTH-1:0] rduty;
		logic                   updated;
	} motor_outputs_t;

	// mirror of the drive: register copies, targets, speeds, and the outputs
	// still owed by the block
	class drive_tracker;
		longint step_size, min_left, min_right;
		longint cur_l, cur_r, tgt_l, tgt_r;
		motor_outputs_t motor_outputs_q[$];
		int errors;
		int n_drive, n_tick, n_stop, n_other, n_cfg;

		function new();
			step_size = ddramp_pkg::RAMP_STEP_RESET;
			min_left  = 0;
			min_right = 0;
			cur_l = 0; cur_r = 0; tgt_l = 0; tgt_r = 0;
			errors = 0;
			n_drive = 0; n_tick = 0; n_stop = 0; n_other = 0; n_cfg = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [SPEED_WIDTH-1:0] val);
			n_cfg++;
			case (idx)
				ddramp_pkg::REG_RAMP_STEP: step_size = val;
				ddramp_pkg::REG_MIN_LEFT:  min_left  = val;
				ddramp_pkg::REG_MIN_RIGHT: min_right = val;
				default: ;
			endcase
		endfunction

		function longint magnitude(longint x);
			return (x < 0) ? -x : x;
		endfunction

		function longint clamp_demand(logic signed [15:0] x);
			longint v;
			v = x;
			if (v > UNITY) v = UNITY;
			if (v < -UNITY) v = -UNITY;
			return v;
		endfunction

		function longint raise_to_min(longint s, longint lo);
			if (s != 0 && magnitude(s) < lo) return (s < 0) ? -lo : lo;
			return s;
		endfunction

		function longint slew(longint c, longint g);
			if (g > c && g > c + step_size) return c + step_size;
			if (g < c && g < c - step_size) return c - step_size;
			return g;
		endfunction

		function void mix(longint t, longint d, longint maxs);
			longint m, l, r, den, nl, nr;
			m = (magnitude(t) > magnitude(d)) ? magnitude(t) : magnitude(d);
			if (magnitude(t) * 10 < UNITY) begin
				// deadband: stop, or turn on the spot
				l = (d * m * maxs) / (UNITY * UNITY);
				r = -l;
			end else begin
				den = UNITY * (magnitude(t) + magnitude(d));
				if (t > 0 && d >= 0) begin
					nl = t + d; nr = t;
				end else if (t < 0 && d < 0) begin
					nl = t; nr = t + d;
				end else if (t < 0 && d > 0) begin
					nl = t - d; nr = t;
				end else begin
					nl = t; nr = t - d;
				end
				l = (nl * m * maxs) / den;
				r = (nr * m * maxs) / den;
			end
			tgt_l = raise_to_min(l, min_left);
			tgt_r = raise_to_min(r, min_right);
		endfunction

		// work out the outputs owed for one accepted request
		function void note_request(logic [1:0] kind, logic [IN_W-1:0] data);
			motor_outputs_t e;
			longint nl, nr;
			bit upd;
			upd = 1'b0;
			case (kind)
				ddramp_pkg::REQ_DRIVE: begin
					n_drive++;
					mix(clamp_demand(data[15:0]), clamp_demand(data[31:16]),
						longint'(data[32 +: SPEED_WIDTH]));
				end
				ddramp_pkg::REQ_TICK: begin
					n_tick++;
					nl = slew(cur_l, tgt_l);
					nr = slew(cur_r, tgt_r);
					upd = (nl != cur_l) || (nr != cur_r);
					cur_l = nl;
					cur_r = nr;
				end
				ddramp_pkg::REQ_STOP: begin
					n_stop++;
					cur_l = 0; cur_r = 0; tgt_l = 0; tgt_r = 0;
					upd = 1'b1;
				end
				default: n_other++;
			endcase
			e.lsense  = (cur_l > 0) ? ddramp_pkg::SENSE_CW :
				((cur_l < 0) ? ddramp_pkg::SENSE_CCW : ddramp_pkg::SENSE_STOP);
			e.lduty   = SPEED_WIDTH'(magnitude(cur_l));
			e.rsense  = (cur_r > 0) ? ddramp_pkg::SENSE_CW :
				((cur_r < 0) ? ddramp_pkg::SENSE_CCW : ddramp_pkg::SENSE_STOP);
			e.rduty   = SPEED_WIDTH'(magnitude(cur_r));
			e.updated = upd;
			motor_outputs_q.push_back(e);
		endfunction

		function void compare_field(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] data, logic upd);
			motor_outputs_t e;
			if (motor_outputs_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, expected none actual %h/%b",
					$time, data, upd);
				return;
			end
			e = motor_outputs_q.pop_front();
			compare_field("left_sense", e.lsense, data[1:0]);
			compare_field("left_duty", e.lduty, data[2 +: SPEED_WIDTH]);
			compare_field("right_sense", e.rsense, data[2+SPEED_WIDTH +: 2]);
			compare_field("right_duty", e.rduty, data[4+SPEED_WIDTH +: SPEED_WIDTH]);
			compare_field("drive_updated", e.updated, upd);
		endfunction

		function int pending();
			return motor_outputs_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata = '0;
	logic [1:0]             s_tuser = ddramp_pkg::REQ_DRIVE;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_W-1:0]       m_tdata;
	logic                   m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index = ddramp_pkg::REG_RAMP_STEP;
	logic [SPEED_WIDTH-1:0] cfg_data = '0;

	drive_tracker tracker;
	int  tx_idle = 0;       // percent of cycles the sender holds back
	int  rx_idle = 0;       // percent of cycles the receiver drops ready
	logic rx_hold = 1'b0;   // long receiver hold-off
	int  cycles = 0;

	differential_drive_ramp dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				tracker.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver ready, random per cycle unless held off
	always @(posedge clk) begin
		m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle);
	end

	// monitors: note every accepted request, check every accepted result
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) tracker.note_request(s_tuser, s_tdata);
		if (arst_n && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
	end

	// offer one request and hold it until taken; valid stays high so the next
	// request can follow back to back
	task automatic send_request(logic [1:0] kind, logic [15:0] thr, logic [15:0] dir,
		logic [SPEED_WIDTH-1:0] ms);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_W'({ms, dir, thr});
		do @(posedge clk); while (!s_tready);
	endtask

	// stop offering and wait until every owed result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// valid drops over an edge after each write, so it is never set twice at one edge
	task automatic write_reg(logic [1:0] idx, logic [SPEED_WIDTH-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.set_reg(idx, val);
		@(posedge clk);
	endtask

	// registers only change with the block idle
	task automatic set_config(logic [SPEED_WIDTH-1:0] step, logic [SPEED_WIDTH-1:0] lo_l,
		logic [SPEED_WIDTH-1:0] lo_r);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(ddramp_pkg::REG_RAMP_STEP, step);
		write_reg(ddramp_pkg::REG_MIN_LEFT, lo_l);
		write_reg(ddramp_pkg::REG_MIN_RIGHT, lo_r);
	endtask

	// demand values with weight on the extremes and the deadband edge
	function automatic logic [15:0] pick_demand();
		logic [15:0] v;
		case ($urandom_range(9))
			4: begin
				v = 16'($urandom_range(3285, 3268));
				if ($urandom_range(1)) v = -v;
			end
			5: v = 16'd0;
			6: v = 16'h7fff;
			7: v = 16'h8000;
			8: v = 16'($urandom_range(8000) - 4000);
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [SPEED_WIDTH-1:0] pick_speed();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return SPEED_WIDTH'($urandom_range(50, 1));
			default: return SPEED_WIDTH'($urandom);
		endcase
	endfunction

	task automatic tick_run(int n);
		repeat (n) send_request(ddramp_pkg::REQ_TICK, 16'($urandom), 16'($urandom),
			SPEED_WIDTH'($urandom));
	endtask

	// mostly a command followed by a run of ticks that chase its targets,
	// with stops, lone tick runs and unused kinds mixed in
	task automatic run_random(int count);
		int issued;
		int k;
		issued = 0;
		while (issued < count) begin
			case ($urandom_range(19))
				0, 1: begin
					send_request(ddramp_pkg::REQ_STOP, 16'($urandom), 16'($urandom),
						SPEED_WIDTH'($urandom));
					issued++;
				end
				2: begin
					send_request(REQ_UNUSED, 16'($urandom), 16'($urandom),
						SPEED_WIDTH'($urandom));
				end
				3, 4, 5: begin
					k = $urandom_range(20, 1);
					tick_run(k);
					issued += k;
				end
				default: begin
					k = $urandom_range(10);
					send_request(ddramp_pkg::REQ_DRIVE, pick_demand(), pick_demand(),
						pick_speed());
					tick_run(k);
					issued += k + 1;
				end
			endcase
		end
	endtask

	initial begin
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings, no idling
		send_request(ddramp_pkg::REQ_TICK, 16'h0000, 16'h0000, 12'd0);       // tick at rest
		send_request(ddramp_pkg::REQ_DRIVE, 16'h7fff, 16'h0000, 12'hfff);    // full forward
		tick_run(3);
		// both negative, at minus one
		send_request(ddramp_pkg::REQ_DRIVE, 16'h8000, 16'h8000, 12'hfff);
		tick_run(2);
		// back, turning right
		send_request(ddramp_pkg::REQ_DRIVE, 16'h8000, 16'h7fff, 12'hfff);
		tick_run(1);
		// forward, turning left
		send_request(ddramp_pkg::REQ_DRIVE, 16'h7fff, 16'h8000, 12'hfff);
		tick_run(1);
		// turn on the spot
		send_request(ddramp_pkg::REQ_DRIVE, 16'd3276, 16'd20000, 12'hfff);
		tick_run(1);
		// just outside deadband
		send_request(ddramp_pkg::REQ_DRIVE, -16'sd3277, 16'h0000, 12'd1000);
		// deadband, no turn
		send_request(ddramp_pkg::REQ_DRIVE, 16'h0000, 16'h0000, 12'hfff);
		tick_run(1);
		send_request(REQ_UNUSED, 16'hffff, 16'hffff, 12'hfff);   // unused kind
		send_request(ddramp_pkg::REQ_STOP, 16'h0000, 16'h0000, 12'd0);
		tick_run(1);
		// zero max speed
		send_request(ddramp_pkg::REQ_DRIVE, 16'd20000, 16'd5000, 12'd0);
		tick_run(1);

		// zero ramp step and minimum speeds that lift small targets
		set_config(12'd0, 12'd300, 12'hfff);
		send_request(ddramp_pkg::REQ_DRIVE, 16'h7fff, 16'd100, 12'd10);
		tick_run(2);
		send_request(ddramp_pkg::REQ_STOP, 16'h0000, 16'h0000, 12'd0);
		tick_run(1);
		drain_results();
		write_reg(REG_UNUSED, SPEED_WIDTH'($urandom));

		// long receiver hold-off while the sender keeps offering, so the block
		// fills up and stalls its input; then the sender waits for all results
		set_config(12'd50, 12'd0, 12'd0);
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (6) begin
			send_request(ddramp_pkg::REQ_DRIVE, pick_demand(), pick_demand(), pick_speed());
			tick_run(2);
		end
		drain_results();

		// random phases: sender idles 26 / receiver 80, then the other way round,
		// then no idling at all
		tx_idle = 26; rx_idle = 80;
		set_config(12'd200, 12'd0, 12'd0);
		run_random(330);
		set_config(12'd1, 12'hfff, 12'hfff);
		run_random(330);

		tx_idle = 80; rx_idle = 26;
		set_config(12'hfff, 12'd0, 12'd0);
		write_reg(REG_UNUSED, SPEED_WIDTH'($urandom));
		run_random(330);
		set_config(SPEED_WIDTH'($urandom_range(4095, 1)), SPEED_WIDTH'($urandom),
			SPEED_WIDTH'($urandom));
		run_random(330);

		tx_idle = 0; rx_idle = 0;
		set_config(SPEED_WIDTH'($urandom_range(400, 1)), SPEED_WIDTH'($urandom_range(200)),
			SPEED_WIDTH'($urandom_range(200)));
		run_random(330);
		set_config(SPEED_WIDTH'($urandom_range(4095, 1)), SPEED_WIDTH'($urandom),
			SPEED_WIDTH'($urandom));
		run_random(330);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d drive commands, %0d ticks, %0d stops, %0d unused kinds",
			tracker.n_drive, tracker.n_tick, tracker.n_stop, tracker.n_other);
		$display("with %0d register writes over %0d cycles, %0d mismatches",
			tracker.n_cfg, cycles, tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/ddramp_pkg.sv
rtl/ddramp_ctrl.sv
rtl/ddramp_dp.sv
rtl/differential_drive_ramp.sv
rtl/ddramp_checker.sv
sim/tb_top.sv
